// ===== hw/rtl/frtc_pkg.sv =====
// shared types, codes and helpers for the flywheel ramp and toggle controller
package frtc_pkg;

   localparam int DRIVE_BITS = 11;
   localparam int TGT_BITS   = 11;
   localparam int STEP_BITS  = 8;
   localparam int BAND_BITS  = 8;
   localparam int WIDE_BITS  = (DRIVE_BITS > TGT_BITS) ? DRIVE_BITS : TGT_BITS;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 11;

   localparam logic [DRIVE_BITS-1:0] DRIVE_MAX = {DRIVE_BITS{1'b1}};

   // tick kinds
   localparam logic [1:0] MODE_REMOTE  = 2'd0;
   localparam logic [1:0] MODE_KEY     = 2'd1;
   localparam logic [1:0] MODE_PROTECT = 2'd2;

   // switch positions
   localparam logic [1:0] SW_UP   = 2'd1;
   localparam logic [1:0] SW_DOWN = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RAMP_STEP  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_READY_BAND = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REMOTE_TGT = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KEY_TGT    = 2'd3;

   localparam logic [STEP_BITS-1:0] RAMP_STEP_RST  = 8'd5;
   localparam logic [BAND_BITS-1:0] READY_BAND_RST = 8'd20;
   localparam logic [TGT_BITS-1:0]  REMOTE_TGT_RST = 11'd350;
   localparam logic [TGT_BITS-1:0]  KEY_TGT_RST    = 11'd563;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] switch_one;
      logic [1:0] switch_two;
      logic       mouse_left;
      logic       reset_request;
   } req_type;

   typedef struct packed {
      logic [DRIVE_BITS-1:0] drive;
      logic                  wheel_on;
      logic                  ready_res;
      logic                  resetting;
   } rsp_type;

   typedef struct packed {
      logic [STEP_BITS-1:0] ramp_step;
      logic [BAND_BITS-1:0] ready_band;
      logic [TGT_BITS-1:0]  remote_on_target;
      logic [TGT_BITS-1:0]  key_on_target;
   } cfg_type;

   // clip a target to the drive range
   function automatic logic [DRIVE_BITS-1:0] sat_drive(input logic [TGT_BITS-1:0] v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      if (w > WIDE_BITS'(DRIVE_MAX)) return DRIVE_MAX;
      return DRIVE_BITS'(w);
   endfunction

   // one step down, floored at zero
   function automatic logic [DRIVE_BITS-1:0] step_down(input logic [DRIVE_BITS-1:0] lvl,
                                                       input logic [STEP_BITS-1:0] stp);
      logic [DRIVE_BITS-1:0] s;
      s = DRIVE_BITS'(stp);
      return (lvl >= s) ? lvl - s : '0;
   endfunction

endpackage

// ===== hw/rtl/flywheel_ramp_toggle_controller.sv =====
// flywheel ramp and toggle controller top level
// Usage:
//  - one request is one control tick (mode, switches, mouse, reset request);
//    it is taken when req_valid is high and req_stall is low
//  - every request gives exactly one response on rsp_data: drive value,
//    wheel on/laser flag, ready flag and the wheel reset flag
//  - a request lands in an input register; once the response register can
//    advance, the tick logic updates the wheel state and loads the response
//    register, which drives rsp_valid
//  - one request per cycle is sustained while rsp_stall is low; the tick logic
//    updates the wheel state once per taken tick and the next request sees it right away
//  - csr_wr_en writes register csr_index (ramp step, ready band, remote
//    target, key target) with csr_wdata; write only while no request is
//    in flight
//  - reset (synchronous) empties both registers, loads the register
//    defaults, turns the wheel off and sets the reset flag
//  - when rsp_stall holds a response, the input register still fills once,
//    then req_stall rises until the response is taken
module flywheel_ramp_toggle_controller
   import frtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   logic    in_load;
   cfg_type cfg;
   rsp_type tick_rsp;

   assign advance      = !out_valid_ff || !rsp_stall;
   assign in_load      = !in_valid_ff || advance;
   assign req_stall    = !in_load;
   assign in_valid_in  = in_load ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   frtc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   frtc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .tick_en (advance && in_valid_ff),
      .cfg     (cfg),
      .req     (in_data_ff),
      .rsp     (tick_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) in_data_ff <= req_data;
      if (advance && in_valid_ff) out_data_ff <= tick_rsp;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hw/rtl/frtc_csr.sv =====
// configuration registers of the flywheel controller
module frtc_csr
   import frtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RAMP_STEP:  cfg_in.ramp_step        = csr_wdata[STEP_BITS-1:0];
            CSR_READY_BAND: cfg_in.ready_band       = csr_wdata[BAND_BITS-1:0];
            CSR_REMOTE_TGT: cfg_in.remote_on_target = csr_wdata[TGT_BITS-1:0];
            CSR_KEY_TGT:    cfg_in.key_on_target    = csr_wdata[TGT_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step        <= RAMP_STEP_RST;
         cfg_ff.ready_band       <= READY_BAND_RST;
         cfg_ff.remote_on_target <= REMOTE_TGT_RST;
         cfg_ff.key_on_target    <= KEY_TGT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/frtc_core.sv =====
// wheel state and per-tick toggle, reset-ramp and slew logic
module frtc_core
   import frtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    tick_en,
   input  cfg_type cfg,
   input  req_type req,
   output rsp_type rsp
);

   logic                  on_ff, on_in;
   logic [DRIVE_BITS-1:0] target_ff, target_in;
   logic [DRIVE_BITS-1:0] level_ff, level_in;
   logic [1:0]            last_sw_ff, last_sw_in;
   logic                  rflag_ff, rflag_in;

   logic                  rflag;
   logic [DRIVE_BITS-1:0] lvl_a;
   logic [DRIVE_BITS:0]   up_sum;
   logic [DRIVE_BITS-1:0] dn_val;
   logic [DRIVE_BITS-1:0] diff;

   always_comb begin
      rflag      = rflag_ff | req.reset_request;
      on_in      = on_ff;
      target_in  = target_ff;
      last_sw_in = last_sw_ff;
      rflag_in   = rflag;
      lvl_a      = level_ff;
      level_in   = level_ff;
      up_sum     = '0;
      dn_val     = '0;

      if (req.mode == MODE_PROTECT) begin
         on_in      = 1'b0;
         target_in  = '0;
         level_in   = step_down(level_ff, cfg.ramp_step);
         last_sw_in = SW_UP;
      end else begin
         if (req.mode == MODE_KEY) last_sw_in = req.switch_one;
         if (rflag) begin
            if (level_ff != '0) begin
               on_in     = 1'b0;
               target_in = '0;
               lvl_a     = step_down(level_ff, cfg.ramp_step);
            end else begin
               rflag_in = 1'b0;
            end
         end else if (req.mode == MODE_REMOTE) begin
            if (req.switch_one == SW_UP && last_sw_ff != SW_UP &&
                req.switch_two == SW_DOWN) begin
               if (!on_ff) begin
                  on_in     = 1'b1;
                  target_in = sat_drive(cfg.remote_on_target);
               end else begin
                  on_in     = 1'b0;
                  target_in = '0;
               end
            end
            last_sw_in = req.switch_one;
         end else if (req.mode == MODE_KEY) begin
            if (!on_ff && req.mouse_left) begin
               on_in     = 1'b1;
               target_in = sat_drive(cfg.key_on_target);
            end
         end

         // slew toward the target, never past it
         up_sum = {1'b0, lvl_a} + (DRIVE_BITS+1)'(cfg.ramp_step);
         dn_val = step_down(lvl_a, cfg.ramp_step);
         if (lvl_a < target_in) begin
            level_in = (up_sum > {1'b0, target_in}) ? target_in : up_sum[DRIVE_BITS-1:0];
         end else if (lvl_a > target_in) begin
            level_in = (dn_val < target_in) ? target_in : dn_val;
         end else begin
            level_in = lvl_a;
         end
      end

      diff = (target_in > level_in) ? target_in - level_in : level_in - target_in;

      rsp.drive     = level_in;
      rsp.wheel_on  = on_in;
      rsp.ready_res = on_in && (diff <= DRIVE_BITS'(cfg.ready_band));
      rsp.resetting = rflag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff      <= 1'b0;
         target_ff  <= '0;
         level_ff   <= '0;
         last_sw_ff <= SW_UP;
         rflag_ff   <= 1'b1;
      end else if (tick_en) begin
         on_ff      <= on_in;
         target_ff  <= target_in;
         level_ff   <= level_in;
         last_sw_ff <= last_sw_in;
         rflag_ff   <= rflag_in;
      end
   end

endmodule

// ===== hw/rtl/frtc_checker.sv =====
// port-level checks for the flywheel controller and their bind
module frtc_checker
   import frtc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // no response right after reset
   a_rst_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // requests only back up behind a waiting response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // ready only while the wheel is on
   a_ready_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ready_res |-> rsp_data.wheel_on)
      else $error("ready with wheel off");

   // wheel never reported on while the reset ramp is active
   a_reset_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.resetting |-> !rsp_data.wheel_on)
      else $error("wheel on during reset ramp");

endmodule

bind flywheel_ramp_toggle_controller frtc_checker u_frtc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/frtc_checker.sv =====
// watches the tick and response channels, predicts each response and compares
`timescale 1ns / 1ps

module frtc_monitor
   import frtc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       fail_count,
   output int                       pending_count
);

   localparam int DRIVE_TOP = (1 << DRIVE_BITS) - 1;

   // register copies
   int step_cfg;
   int band_cfg;
   int remote_cfg;
   int key_cfg;

   // wheel state
   logic       wheel;
   int         tgt;
   int         lvl;
   logic [1:0] last_sw;
   logic       rst_flag;

   rsp_type pending_outputs[$];

   function automatic int clip_target(input int v);
      return (v > DRIVE_TOP) ? DRIVE_TOP : v;
   endfunction

   task automatic halt_wheel();
      wheel = 1'b0;
      tgt   = 0;
      if (lvl > 0)
         lvl = (lvl >= step_cfg) ? lvl - step_cfg : 0;
   endtask

   task automatic advance_wheel(input req_type r, output rsp_type o);
      int diff;
      int nxt;
      if (r.reset_request)
         rst_flag = 1'b1;
      if (r.mode == MODE_PROTECT) begin
         halt_wheel();
         last_sw = SW_UP;
      end else begin
         if (r.mode == MODE_KEY)
            last_sw = r.switch_one;
         if (rst_flag) begin
            if (lvl != 0)
               halt_wheel();
            else
               rst_flag = 1'b0;
         end else if (r.mode == MODE_REMOTE) begin
            // rising into up with the right switch down toggles
            if (r.switch_one == SW_UP && last_sw != SW_UP && r.switch_two == SW_DOWN) begin
               if (!wheel) begin
                  wheel = 1'b1;
                  tgt   = clip_target(remote_cfg);
               end else begin
                  wheel = 1'b0;
                  tgt   = 0;
               end
            end
            last_sw = r.switch_one;
         end else if (r.mode == MODE_KEY) begin
            if (!wheel && r.mouse_left) begin
               wheel = 1'b1;
               tgt   = clip_target(key_cfg);
            end
         end
         // slew toward target
         if (lvl < tgt) begin
            nxt = lvl + step_cfg;
            lvl = (nxt > tgt) ? tgt : nxt;
         end else if (lvl > tgt) begin
            nxt = (lvl >= step_cfg) ? lvl - step_cfg : 0;
            lvl = (nxt < tgt) ? tgt : nxt;
         end
      end
      diff        = (tgt > lvl) ? tgt - lvl : lvl - tgt;
      o.drive     = lvl[DRIVE_BITS-1:0];
      o.wheel_on  = wheel;
      o.ready_res = wheel && (diff <= band_cfg);
      o.resetting = rst_flag;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         fail_count = 0;
         step_cfg   = int'(RAMP_STEP_RST);
         band_cfg   = int'(READY_BAND_RST);
         remote_cfg = int'(REMOTE_TGT_RST);
         key_cfg    = int'(KEY_TGT_RST);
         wheel      = 1'b0;
         tgt        = 0;
         lvl        = 0;
         last_sw    = SW_UP;
         rst_flag   = 1'b1;
         pending_outputs.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RAMP_STEP:  step_cfg   = int'(csr_wdata[STEP_BITS-1:0]);
               CSR_READY_BAND: band_cfg   = int'(csr_wdata[BAND_BITS-1:0]);
               CSR_REMOTE_TGT: remote_cfg = int'(csr_wdata[TGT_BITS-1:0]);
               CSR_KEY_TGT:    key_cfg    = int'(csr_wdata[TGT_BITS-1:0]);
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (pending_outputs.size() == 0) begin
               $error("response with no request pending: drive %0d", got.drive);
               fail_count++;
            end else begin
               want = pending_outputs.pop_front();
               if (got.drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", want.drive, got.drive);
                  fail_count++;
               end
               if (got.wheel_on !== want.wheel_on) begin
                  $error("wheel_on: expected %0d, got %0d", want.wheel_on, got.wheel_on);
                  fail_count++;
               end
               if (got.ready_res !== want.ready_res) begin
                  $error("ready_res: expected %0d, got %0d", want.ready_res, got.ready_res);
                  fail_count++;
               end
               if (got.resetting !== want.resetting) begin
                  $error("resetting: expected %0d, got %0d", want.resetting, got.resetting);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            advance_wheel(req_data, want);
            pending_outputs.push_back(want);
         end
      end
      pending_count = pending_outputs.size();
   end

endmodule

// ===== tb/testbench.sv =====
// stimulus and verdict for the flywheel ramp and toggle controller
`timescale 1ns / 1ps

module testbench;
   import frtc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_TICKS = 170;
   localparam int DRAIN_WAIT  = 4;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] SW_MID     = 2'd3;
   localparam logic [1:0] SW_NONE    = 2'd0;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_wr_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   int fail_count;
   int pending_count;
   int idle_pct  = 0;
   int stall_pct = 0;

   flywheel_ramp_toggle_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frtc_monitor u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("** flywheel_ramp_toggle_controller: FAILED **");
      $finish;
   end

   function automatic req_type tick_of(input logic [1:0] mode, input logic [1:0] sw1,
                                       input logic [1:0] sw2, input logic mouse,
                                       input logic rst_req);
      req_type r;
      r.mode          = mode;
      r.switch_one    = sw1;
      r.switch_two    = sw2;
      r.mouse_left    = mouse;
      r.reset_request = rst_req;
      return r;
   endfunction

   // mostly clean switch edges and mouse presses, some noise
   function automatic req_type random_tick();
      req_type r;
      int      pick;
      r    = req_type'($bits(req_type)'($urandom));
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.mode       = MODE_REMOTE;
         r.switch_one = $urandom_range(1) ? SW_UP : SW_DOWN;
         if ($urandom_range(99) < 80)
            r.switch_two = SW_DOWN;
      end else if (pick < 60) begin
         r.mode = MODE_REMOTE;
      end else if (pick < 80) begin
         r.mode       = MODE_KEY;
         r.mouse_left = ($urandom_range(99) < 30);
      end else if (pick < 88) begin
         r.mode = MODE_SPARE;
      end else if (pick < 94) begin
         r.mode = MODE_PROTECT;
      end
      r.reset_request = ($urandom_range(99) < 3);
      return r;
   endfunction

   // called at a falling edge, returns at a falling edge with the request taken
   task automatic send_tick(input req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic program_regs(input int step, input int band, input int rtgt, input int ktgt);
      int vals[4];
      vals[0] = step;
      vals[1] = band;
      vals[2] = rtgt;
      vals[3] = ktgt;
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_BITS'(i);
         csr_wdata <= CSR_DATA_BITS'(vals[i]);
         @(negedge clock);
      end
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed ticks on the reset register values
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_DOWN, 1'b0, 1'b0));   // clears reset flag
      send_tick(tick_of(MODE_REMOTE, SW_DOWN, SW_DOWN, 1'b0, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_DOWN, 1'b0, 1'b0));   // remote on
      repeat (4) send_tick(tick_of(MODE_REMOTE, SW_MID, SW_MID, 1'b0, 1'b0));
      send_tick(tick_of(MODE_KEY, SW_MID, SW_MID, 1'b1, 1'b0));      // press while on
      send_tick(tick_of(MODE_REMOTE, SW_DOWN, SW_MID, 1'b0, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_UP, 1'b0, 1'b0));     // right switch not down
      send_tick(tick_of(MODE_REMOTE, SW_DOWN, SW_DOWN, 1'b0, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_DOWN, 1'b0, 1'b0));   // remote off
      send_tick(tick_of(MODE_KEY, SW_DOWN, SW_MID, 1'b1, 1'b0));     // key on
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_DOWN, 1'b0, 1'b0));   // edge after key tick
      send_tick(tick_of(MODE_KEY, SW_UP, SW_DOWN, 1'b1, 1'b0));
      send_tick(tick_of(MODE_SPARE, SW_DOWN, SW_DOWN, 1'b1, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_NONE, SW_NONE, 1'b1, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_UP, SW_DOWN, 1'b0, 1'b0));   // from unused code
      send_tick(tick_of(MODE_REMOTE, SW_MID, SW_MID, 1'b0, 1'b1));   // reset request
      send_tick(tick_of(MODE_KEY, SW_MID, SW_MID, 1'b1, 1'b0));
      send_tick(tick_of(MODE_PROTECT, SW_DOWN, SW_DOWN, 1'b1, 1'b1));
      send_tick(tick_of(MODE_PROTECT, SW_UP, SW_UP, 1'b0, 1'b0));
      send_tick(tick_of(MODE_REMOTE, SW_MID, SW_NONE, 1'b0, 1'b0));

      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         if (p == 0)
            program_regs(1, 0, 2047, 0);
         else if (p == 1)
            program_regs(255, 255, 0, 2047);
         else
            program_regs($urandom_range(1) ? $urandom_range(1, 40) : $urandom_range(1, 255),
                         $urandom_range(0, 255), $urandom_range(0, 2047),
                         $urandom_range(0, 2047));
         for (int n = 0; n < PHASE_TICKS; n++) begin
            if (n == PHASE_TICKS / 2 && p == 5)
               wait_idle();   // sender holds off until every response is back
            send_tick(random_tick());
         end
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("** flywheel_ramp_toggle_controller: PASSED **");
      else
         $display("** flywheel_ramp_toggle_controller: FAILED **");
      $finish;
   end

endmodule
